@@ rtl/pooled_doubly_linked_list_core_defines.svh @@
// ---------------------------------------------------------------------------
// pooled doubly linked list core - assertion macros
// implication checks clocked on i_clk, disabled during reset
// ---------------------------------------------------------------------------
`ifndef POOLED_DOUBLY_LINKED_LIST_CORE_DEFINES_SVH
`define POOLED_DOUBLY_LINKED_LIST_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PDL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pdl assertion failed");
`define PDL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pdl assertion failed");
`else
`define PDL_ASSERT_SAME(lbl, ante, cons)
`define PDL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/pdl_pkg.sv @@
// ---------------------------------------------------------------------------
// pdl_pkg
// sizes, codes and helpers of the pooled doubly linked list core
// ---------------------------------------------------------------------------
package pdl_pkg;
    localparam int POOL_DEPTH    = 16;
    localparam int KEY_WIDTH     = 32;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int IDX_W         = $clog2(POOL_DEPTH);
    localparam int LINK_W        = $clog2(POOL_DEPTH + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

    typedef enum logic [2:0] {
        ACT_CLEAR    = 3'd0,
        ACT_INS_HEAD = 3'd1,
        ACT_INS_TAIL = 3'd2,
        ACT_INS_AFT  = 3'd3,
        ACT_DELETE   = 3'd4,
        ACT_SEARCH   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_BAD_ANCHOR = 2'd3
    } t_status;

    function automatic logic is_slot(input logic [LINK_W-1:0] link);
        return link < LINK_W'(POOL_DEPTH);
    endfunction
endpackage

@@ rtl/pdl_ram.sv @@
// ---------------------------------------------------------------------------
// pdl_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module pdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/pooled_doubly_linked_list_core.sv @@
// ---------------------------------------------------------------------------
// pooled doubly linked list core
// one doubly linked list over a fixed node pool, links and data in rams
// ---------------------------------------------------------------------------
// channel  direction  signals
// in       sink       i_in_valid / o_in_ready, action key payload anchor_index
// out      source     o_out_valid / i_out_ready, status slot key payload
//
// clear, unused actions and failed requests go straight to done; insert head
// passes node, fix and done; insert after reads the anchor first. search,
// delete and insert tail walk the list: read (ram latency), check per node.
// synchronous reset empties the list at once; ram contents need no clearing.
// a new beat is taken whenever the sequencer is idle, even while a result
// waits on the output register.
`include "pooled_doubly_linked_list_core_defines.svh"
module pooled_doubly_linked_list_core
    import pdl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_key,
    input  logic [31:0] i_payload,
    input  logic [3:0]  i_anchor_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot_index,
    output logic [31:0] o_found_key,
    output logic [31:0] o_found_payload
);
    typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_NODE, S_FIX, S_DONE} t_state;

    t_state                   r_state;
    logic [POOL_DEPTH-1:0]    r_used;
    logic [LINK_W-1:0]        r_head;
    t_action                  r_act;
    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_pay;
    logic [IDX_W-1:0]         r_slot;
    logic [IDX_W-1:0]         r_cur;
    logic [LINK_W-1:0]        r_node_next;
    logic [LINK_W-1:0]        r_node_prev;
    logic                     r_fix_next_en;
    logic [IDX_W-1:0]         r_fix_next_addr;
    logic [LINK_W-1:0]        r_fix_next_data;
    logic                     r_fix_prev_en;
    logic [IDX_W-1:0]         r_fix_prev_addr;
    logic [LINK_W-1:0]        r_fix_prev_data;
    logic                     r_head_en;
    logic [LINK_W-1:0]        r_head_val;
    t_status                  r_res_status;
    logic [IDX_W-1:0]         r_res_slot;
    logic [KEY_WIDTH-1:0]     r_res_key;
    logic [PAYLOAD_WIDTH-1:0] r_res_pay;
    logic                     r_out_valid;
    t_status                  r_o_status;
    logic [IDX_W-1:0]         r_o_slot;
    logic [KEY_WIDTH-1:0]     r_o_key;
    logic [PAYLOAD_WIDTH-1:0] r_o_pay;

    logic                     free_any;
    logic [IDX_W-1:0]         free_idx;
    logic                     anchor_ok;
    logic [IDX_W-1:0]         anchor_idx;
    logic                     in_beat;
    logic [LINK_W-1:0]        rd_next;
    logic [LINK_W-1:0]        rd_prev;
    logic [KEY_WIDTH-1:0]     rd_key;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;
    logic                     next_we;
    logic [IDX_W-1:0]         next_waddr;
    logic [LINK_W-1:0]        next_wdata;
    logic                     prev_we;
    logic [IDX_W-1:0]         prev_waddr;
    logic [LINK_W-1:0]        prev_wdata;
    logic                     node_we;
    logic                     key_hit;

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign anchor_idx = IDX_W'(i_anchor_index);
    assign anchor_ok  = (32'(i_anchor_index) < 32'(POOL_DEPTH)) && r_used[anchor_idx];
    assign in_beat    = i_in_valid && (r_state == S_IDLE);
    assign key_hit    = (rd_key == r_key);

    assign node_we    = (r_state == S_NODE);
    assign next_we    = node_we || ((r_state == S_FIX) && r_fix_next_en);
    assign next_waddr = node_we ? r_slot : r_fix_next_addr;
    assign next_wdata = node_we ? r_node_next : r_fix_next_data;
    assign prev_we    = node_we || ((r_state == S_FIX) && r_fix_prev_en);
    assign prev_waddr = node_we ? r_slot : r_fix_prev_addr;
    assign prev_wdata = node_we ? r_node_prev : r_fix_prev_data;

    pdl_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_next_ram (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_waddr), .i_wdata(next_wdata),
        .i_raddr(r_cur), .o_rdata(rd_next)
    );
    pdl_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_prev_ram (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_waddr), .i_wdata(prev_wdata),
        .i_raddr(r_cur), .o_rdata(rd_prev)
    );
    pdl_ram #(.WIDTH(KEY_WIDTH), .DEPTH(POOL_DEPTH)) u_key_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(r_slot), .i_wdata(r_key),
        .i_raddr(r_cur), .o_rdata(rd_key)
    );
    pdl_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(POOL_DEPTH)) u_pay_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(r_slot), .i_wdata(r_pay),
        .i_raddr(r_cur), .o_rdata(rd_pay)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_head      <= NULL_LINK;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_act         <= t_action'(i_action);
                        r_key         <= i_key[KEY_WIDTH-1:0];
                        r_pay         <= i_payload[PAYLOAD_WIDTH-1:0];
                        r_slot        <= free_idx;
                        r_fix_next_en <= 1'b0;
                        r_fix_prev_en <= 1'b0;
                        r_head_en     <= 1'b0;
                        r_res_status  <= ST_OK;
                        r_res_slot    <= '0;
                        r_res_key     <= '0;
                        r_res_pay     <= '0;
                        r_state       <= S_DONE;
                        unique case (i_action)
                            ACT_CLEAR: begin
                                r_used <= '0;
                                r_head <= NULL_LINK;
                            end
                            ACT_INS_HEAD: begin
                                if (!free_any) begin
                                    r_res_status <= ST_FULL;
                                end else begin
                                    r_node_next     <= r_head;
                                    r_node_prev     <= NULL_LINK;
                                    r_fix_prev_en   <= is_slot(r_head);
                                    r_fix_prev_addr <= r_head[IDX_W-1:0];
                                    r_fix_prev_data <= LINK_W'(free_idx);
                                    r_head_en       <= 1'b1;
                                    r_head_val      <= LINK_W'(free_idx);
                                    r_state         <= S_NODE;
                                end
                            end
                            ACT_INS_TAIL: begin
                                if (!free_any) begin
                                    r_res_status <= ST_FULL;
                                end else if (!is_slot(r_head)) begin
                                    r_node_next <= NULL_LINK;
                                    r_node_prev <= NULL_LINK;
                                    r_head_en   <= 1'b1;
                                    r_head_val  <= LINK_W'(free_idx);
                                    r_state     <= S_NODE;
                                end else begin
                                    r_cur   <= r_head[IDX_W-1:0];
                                    r_state <= S_RD;
                                end
                            end
                            ACT_INS_AFT: begin
                                if (!anchor_ok) begin
                                    r_res_status <= ST_BAD_ANCHOR;
                                end else if (!free_any) begin
                                    r_res_status <= ST_FULL;
                                end else begin
                                    r_cur   <= anchor_idx;
                                    r_state <= S_RD;
                                end
                            end
                            ACT_DELETE, ACT_SEARCH: begin
                                if (!is_slot(r_head)) begin
                                    r_res_status <= ST_NOT_FOUND;
                                end else begin
                                    r_cur   <= r_head[IDX_W-1:0];
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    priority case (r_act)
                        ACT_INS_TAIL: begin
                            if (is_slot(rd_next)) begin
                                r_cur   <= rd_next[IDX_W-1:0];
                                r_state <= S_RD;
                            end else begin
                                r_node_next     <= NULL_LINK;
                                r_node_prev     <= LINK_W'(r_cur);
                                r_fix_next_en   <= 1'b1;
                                r_fix_next_addr <= r_cur;
                                r_fix_next_data <= LINK_W'(r_slot);
                                r_state         <= S_NODE;
                            end
                        end
                        ACT_INS_AFT: begin
                            r_node_next     <= rd_next;
                            r_node_prev     <= LINK_W'(r_cur);
                            r_fix_next_en   <= 1'b1;
                            r_fix_next_addr <= r_cur;
                            r_fix_next_data <= LINK_W'(r_slot);
                            r_fix_prev_en   <= is_slot(rd_next);
                            r_fix_prev_addr <= rd_next[IDX_W-1:0];
                            r_fix_prev_data <= LINK_W'(r_slot);
                            r_state         <= S_NODE;
                        end
                        default: begin
                            if (key_hit) begin
                                r_res_slot <= r_cur;
                                r_res_key  <= rd_key;
                                r_res_pay  <= rd_pay;
                                if (r_act == ACT_DELETE) begin
                                    r_used[r_cur]   <= 1'b0;
                                    r_fix_next_en   <= is_slot(rd_prev);
                                    r_fix_next_addr <= rd_prev[IDX_W-1:0];
                                    r_fix_next_data <= rd_next;
                                    r_head_en       <= !is_slot(rd_prev);
                                    r_head_val      <= rd_next;
                                    r_fix_prev_en   <= is_slot(rd_next);
                                    r_fix_prev_addr <= rd_next[IDX_W-1:0];
                                    r_fix_prev_data <= rd_prev;
                                    r_state         <= S_FIX;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end else if (is_slot(rd_next)) begin
                                r_cur   <= rd_next[IDX_W-1:0];
                                r_state <= S_RD;
                            end else begin
                                r_res_status <= ST_NOT_FOUND;
                                r_state      <= S_DONE;
                            end
                        end
                    endcase
                end
                S_NODE: begin
                    r_used[r_slot] <= 1'b1;
                    r_res_slot     <= r_slot;
                    r_res_key      <= r_key;
                    r_res_pay      <= r_pay;
                    r_state        <= S_FIX;
                end
                S_FIX: begin
                    if (r_head_en) begin
                        r_head <= r_head_val;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_slot    <= r_res_slot;
                        r_o_key     <= r_res_key;
                        r_o_pay     <= r_res_pay;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_slot_index    = 4'(r_o_slot);
    assign o_found_key     = 32'(r_o_key);
    assign o_found_payload = 32'(r_o_pay);

    `PDL_ASSERT_SAME(a_node_slot_free, r_state == S_NODE, !r_used[r_slot])
    `PDL_ASSERT_NEXT(a_fix_then_done, r_state == S_FIX, r_state == S_DONE)
    `PDL_ASSERT_SAME(a_fail_zero, r_out_valid && r_o_status != ST_OK, r_o_slot == '0 && r_o_key == '0)
endmodule
